/* design/arpc_pkg.sv */
package arpc_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'b1;

  // Item operations.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ARP_RX = 1'b1;

  // ARP header values that a packet must carry, and the request opcode.
  localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
  localparam logic [7:0]  HLEN_MAC       = 8'd6;
  localparam logic [7:0]  PLEN_IPV4      = 8'd4;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;

  // Result kinds.
  localparam logic [1:0] KIND_HIT     = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_ROUTE   = 2'd2;
  localparam logic [1:0] KIND_REPLY   = 2'd3;

  // Classified work handed from the front to the back.
  typedef struct packed {
    logic        learn;  // received packet that passed the filter
    logic        req;    // packet opcode is a request
    logic [31:0] ip;     // query address or sender address
    logic [47:0] mac;    // sender address of a packet
  } cmd_t;

  // Handshake between the queue and the back.
  typedef struct packed {
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic empty;
  } q_sts_t;

endpackage

/* design/arpc_if.sv */
interface arpc_in_if import arpc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] query_ip;
  logic        frame_too_short;
  logic [15:0] hardware_type;
  logic [15:0] protocol_type;
  logic [7:0]  hardware_len;
  logic [7:0]  protocol_len;
  logic [15:0] arp_opcode;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [31:0] target_ip;

  modport source (
    output valid, op, query_ip, frame_too_short, hardware_type, protocol_type,
           hardware_len, protocol_len, arp_opcode, sender_mac, sender_ip, target_ip,
    input  ready
  );
  modport sink (
    input  valid, op, query_ip, frame_too_short, hardware_type, protocol_type,
           hardware_len, protocol_len, arp_opcode, sender_mac, sender_ip, target_ip,
    output ready
  );
endinterface

interface arpc_out_if import arpc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [47:0] peer_mac;
  logic [31:0] peer_ip;
  logic        evicted;
  logic        last;

  modport source (
    output valid, result_kind, peer_mac, peer_ip, evicted, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, peer_mac, peer_ip, evicted, last,
    output ready
  );
endinterface

/* design/arp_cache_and_responder.sv */
// ARP cache and responder.
// The input channel takes one word per item: a lookup (op 0) of query_ip, or
// a received ARP header (op 1). The output channel gives result words of
// kind hit, broadcast request, route found or reply, with last marking the
// final word of an item. Lookups give one word; an accepted packet gives a
// route-found word and, for a request opcode, a reply word after it. Packets
// that fail the header checks or do not target own_ip give no word at all.
// The configuration port takes own_mac (index 0) and own_ip (index 1); only
// own_ip filters packets. Write it only while the block is idle.
// The back end scans the table one entry per cycle through a single memory
// port, and it takes the next item only after loading the last result word of the one before.
// A two-word queue lets the front keep taking items while the back scans.
// Reset clears all valid bits, the replacement pointer and own_ip at once;
// no clearing pass is needed. When the receiver stalls, the result word
// holds in the output register and the back waits, then the queue fills and
// the input ready drops.
module arp_cache_and_responder import arpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  arpc_in_if.sink               in_i,
  arpc_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic   push;
  logic   full;
  cmd_t   push_cmd;
  cmd_t   head_cmd;
  q_ctl_t q_ctl;
  q_sts_t q_sts;

  // The front filters packets and turns each surviving word into a command.
  arpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  arpc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .ctl_i  (q_ctl),
    .sts_o  (q_sts),
    .cmd_o  (head_cmd)
  );

  // The back scans the table, learns addresses and drives result words.
  arpc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_o  (q_ctl),
    .sts_i  (q_sts),
    .cmd_i  (head_cmd),
    .out_o  (out_o)
  );

endmodule

/* design/arpc_front.sv */
module arpc_front import arpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  arpc_in_if.sink               in_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  full_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  logic [31:0] own_ip_q;
  logic        accept;
  logic        pkt_ok;

  // Only the IP address filters packets; the MAC register has no effect on
  // any result, so a write to it is taken and dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == REG_OWN_IP)) begin
      own_ip_q <= cfg_wdata_i[31:0];
    end
  end

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  assign pkt_ok = !in_i.frame_too_short
               && (in_i.hardware_type == HTYPE_ETHERNET)
               && (in_i.protocol_type == PTYPE_IPV4)
               && (in_i.hardware_len == HLEN_MAC)
               && (in_i.protocol_len == PLEN_IPV4)
               && (in_i.target_ip == own_ip_q);

  // A dropped packet never enters the queue.
  assign push_o = accept && ((in_i.op == OP_LOOKUP) || pkt_ok);

  always_comb begin
    cmd_o       = '0;
    cmd_o.learn = (in_i.op == OP_ARP_RX);
    cmd_o.req   = (in_i.arp_opcode == ARP_OP_REQUEST);
    cmd_o.ip    = (in_i.op == OP_LOOKUP) ? in_i.query_ip : in_i.sender_ip;
    cmd_o.mac   = in_i.sender_mac;
  end

endmodule

/* design/arpc_queue.sv */
module arpc_queue import arpc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  cmd_t   cmd_i,
  output logic   full_o,
  input  q_ctl_t ctl_i,
  output q_sts_t sts_o,
  output cmd_t   cmd_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign sts_o.empty = (cnt_q == '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = ctl_i.pop && !sts_o.empty;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* design/arpc_back.sv */
module arpc_back import arpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  output q_ctl_t     ctl_o,
  input  q_sts_t     sts_i,
  input  cmd_t       cmd_i,
  arpc_out_if.source out_o
);

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_EMIT2  = 2'd3;

  logic [1:0]       state_q, state_d;
  cmd_t             cmd_q;
  entry_t           mem [TABLE_ENTRIES];
  entry_t           rd_data_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_vld_q;
  logic [CNT_W-1:0] cnt_q;
  logic             issue;
  logic             scan_start;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [IDX_W-1:0]         ptr_q;

  logic             hit_q, free_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q;
  logic [47:0]      hit_mac_q;
  logic             cmp_match, cmp_free;

  logic             out_free;
  logic             load_first, load_second;
  logic             wr_en;
  logic [IDX_W-1:0] slot_idx;
  logic             slot_evict;

  logic        out_valid_q;
  logic [1:0]  out_kind_q;
  logic [47:0] out_mac_q;
  logic [31:0] out_ip_q;
  logic        out_ev_q;
  logic        out_last_q;

  assign out_free   = !out_valid_q || out_o.ready;
  assign scan_start = (state_q == S_IDLE) && !sts_i.empty;
  assign ctl_o.pop  = scan_start;
  assign issue      = (state_q == S_SCAN) && (cnt_q < CNT_W'(TABLE_ENTRIES));

  assign cmp_match = rd_vld_q && valid_q[rd_idx_q] && (rd_data_q.ip == cmd_q.ip);
  assign cmp_free  = rd_vld_q && !valid_q[rd_idx_q];

  assign load_first  = (state_q == S_DECIDE) && out_free;
  assign load_second = (state_q == S_EMIT2) && out_free;
  assign wr_en       = load_first && cmd_q.learn;

  // Existing entry first, then the lowest free one, then round robin.
  always_comb begin
    slot_evict = 1'b0;
    if (hit_q) begin
      slot_idx = hit_idx_q;
    end else if (free_q) begin
      slot_idx = free_idx_q;
    end else begin
      slot_idx   = ptr_q;
      slot_evict = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (scan_start) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!issue && !rd_vld_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (load_first) begin
          state_d = (cmd_q.learn && cmd_q.req) ? S_EMIT2 : S_IDLE;
        end
      end
      S_EMIT2: begin
        if (load_second) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      valid_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (scan_start) begin
        cnt_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (issue) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (cmp_match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (cmp_free && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (wr_en) begin
        valid_q[slot_idx] <= 1'b1;
        if (slot_evict) begin
          ptr_q <= (ptr_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : ptr_q + 1'b1;
        end
      end
      if (load_first || load_second) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Table memory: one read or one write a cycle, registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[slot_idx] <= '{ip: cmd_q.ip, mac: cmd_q.mac};
    end
    if (issue) begin
      rd_data_q <= mem[cnt_q[IDX_W-1:0]];
      rd_idx_q  <= cnt_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_start) begin
      cmd_q <= cmd_i;
    end
    if (cmp_match && !hit_q) begin
      hit_idx_q <= rd_idx_q;
      hit_mac_q <= rd_data_q.mac;
    end
    if (cmp_free && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (load_first) begin
      out_ip_q <= cmd_q.ip;
      if (cmd_q.learn) begin
        out_kind_q <= KIND_ROUTE;
        out_mac_q  <= cmd_q.mac;
        out_ev_q   <= slot_evict;
        out_last_q <= !cmd_q.req;
      end else begin
        out_kind_q <= hit_q ? KIND_HIT : KIND_REQUEST;
        out_mac_q  <= hit_q ? hit_mac_q : '0;
        out_ev_q   <= 1'b0;
        out_last_q <= 1'b1;
      end
    end else if (load_second) begin
      out_kind_q <= KIND_REPLY;
      out_mac_q  <= cmd_q.mac;
      out_ip_q   <= cmd_q.ip;
      out_ev_q   <= 1'b0;
      out_last_q <= 1'b1;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.peer_mac    = out_mac_q;
  assign out_o.peer_ip     = out_ip_q;
  assign out_o.evicted     = out_ev_q;
  assign out_o.last        = out_last_q;

endmodule

/* design/arpc_checker.sv */
module arpc_checker import arpc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [47:0] out_mac,
  input logic [31:0] out_ip,
  input logic        out_ev,
  input logic        out_last
);

  // A stalled word keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_mac)
      && $stable(out_ip) && $stable(out_ev) && $stable(out_last))
    else $error("stalled result word changed");

  // Only a route-found word may report an eviction.
  a_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ev |-> out_kind == KIND_ROUTE)
    else $error("eviction flag on a word other than route found");

  // Hit, request and reply words always close their item.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == KIND_HIT || out_kind == KIND_REQUEST
      || out_kind == KIND_REPLY) |-> out_last)
    else $error("single-word result without last");

  a_req_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == KIND_REQUEST |-> out_mac == '0)
    else $error("broadcast request with nonzero MAC");

  // The reply to a request follows its route-found word at once.
  a_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && out_kind == KIND_ROUTE && !out_last |=>
      out_valid && out_kind == KIND_REPLY && out_ip == $past(out_ip))
    else $error("reply word missing after route found");

endmodule

bind arp_cache_and_responder arpc_checker u_arpc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_kind  (out_o.result_kind),
  .out_mac   (out_o.peer_mac),
  .out_ip    (out_o.peer_ip),
  .out_ev    (out_o.evicted),
  .out_last  (out_o.last)
);
